### rtl/lzwd_pkg.sv
// Shared types and constants of the LZW code decoder.
// No dependencies; used by lzwd_ctrl, lzwd_dp and lzw_code_decoder.
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

    localparam int DICT_DEPTH_DEF = 512;
    localparam int CODE_W         = 9;
    localparam int BYTE_W         = 8;
    localparam int NF_W           = 10;
    localparam int ROOTS          = 256;
    localparam int BEAT_BYTES     = 8;
    localparam int BCNT_W         = 4;
    localparam int PCNT_W         = 3;

    // What an incoming code asks for.
    typedef logic [1:0] t_dec;
    localparam t_dec DEC_ERR   = 2'd0;
    localparam t_dec DEC_FIRST = 2'd1;
    localparam t_dec DEC_CODE  = 2'd2;
    localparam t_dec DEC_KWK   = 2'd3;

    typedef struct packed {
        logic accept;
        logic walk;
        logic add;
        logic emit;
        logic err;
    } t_cmd;

    typedef struct packed {
        t_dec dec;
        logic walk_done;
        logic emit_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/lzwd_ctrl.sv
// Sequencer of the LZW code decoder: accept, chain walk, dictionary add, emit, or an error beat.
// Depends on lzwd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_ctrl import lzwd_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_status.dec)
                        DEC_ERR:   n_state = S_ERR;
                        DEC_FIRST: n_state = S_EMIT;
                        default:   n_state = S_WALK;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_done) n_state = S_IDLE;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/lzwd_dp.sv
// Datapath of the LZW code decoder: dictionary memory, reverse stack,
// byte packer and output register. Depends on lzwd_pkg; driven by lzwd_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lzwd_dp import lzwd_pkg::*; #(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  [CODE_W-1:0]                     i_code,
    input  wire                                   i_new_stream,
    input  t_cmd                                  i_cmd,
    output t_status                               o_status,
    input  wire                                   i_stall,
    output logic                                  o_valid,
    output logic [BEAT_BYTES-1:0][BYTE_W-1:0]     o_bytes,
    output logic [BCNT_W-1:0]                     o_byte_count,
    output logic                                  o_last,
    output logic                                  o_error
);

    localparam int STORE_DEPTH = DICT_DEPTH - ROOTS;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W       = $clog2(STORE_DEPTH + 3);
    localparam int ENT_W       = CODE_W + BYTE_W;

    // Dictionary: prefix code above suffix byte, one entry per code from 256.
    logic [ENT_W-1:0]  dict_mem [STORE_DEPTH];
    logic [ENT_W-1:0]  r_dict_q;
    logic [BYTE_W-1:0] stack_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_stk_q;

    logic [NF_W-1:0]   r_next_free;
    logic [CODE_W-1:0] r_prev_code;
    logic              r_seen;
    logic              r_halted;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] r_walk;
    logic              r_use_mem;
    logic [BYTE_W-1:0] r_head;
    logic              r_extra;
    logic [POS_W-1:0]  r_sp;
    logic [POS_W-1:0]  r_pos;
    logic [BEAT_BYTES-1:0][BYTE_W-1:0] r_pack;
    logic [PCNT_W-1:0] r_pcnt;

    logic              r_ov;
    logic [BEAT_BYTES-1:0][BYTE_W-1:0] r_obytes;
    logic [BCNT_W-1:0] r_ocnt;
    logic              r_olast;
    logic              r_oerr;

    // Decision on the offered code, with a stream restart applied first.
    logic [NF_W-1:0]   eff_nf;
    logic              eff_halt;
    logic              eff_seen;
    logic [NF_W-1:0]   code_ext;
    t_dec              dec;

    always_comb begin
        eff_nf   = i_new_stream ? NF_W'(ROOTS) : r_next_free;
        eff_halt = r_halted & ~i_new_stream;
        eff_seen = r_seen & ~i_new_stream;
        code_ext = {1'b0, i_code};
        if (eff_halt) begin
            dec = DEC_ERR;
        end else if (!eff_seen) begin
            dec = i_code[CODE_W-1] ? DEC_ERR : DEC_FIRST;
        end else if (code_ext < eff_nf) begin
            dec = DEC_CODE;
        end else if (code_ext == eff_nf && eff_nf < NF_W'(DICT_DEPTH)) begin
            dec = DEC_KWK;
        end else begin
            dec = DEC_ERR;
        end
    end

    // Chain walk: the registered dictionary read feeds the next address.
    logic [CODE_W-1:0] cur;
    logic              walk_done;
    logic [IDX_W-1:0]  dict_raddr;
    logic              dict_we;

    assign cur        = r_use_mem ? r_dict_q[ENT_W-1:BYTE_W] : r_walk;
    assign walk_done  = ~cur[CODE_W-1];
    assign dict_raddr = cur[IDX_W-1:0];
    assign dict_we    = i_cmd.add && (r_next_free < NF_W'(DICT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            dict_mem[r_next_free[IDX_W-1:0]] <= {r_prev_code, r_head};
        end
        r_dict_q <= dict_mem[dict_raddr];
    end

    // Emit: position 0 is the head byte, then the stack top down, then the
    // head byte again when the code was the next free one.
    logic [POS_W-1:0]  last_pos;
    logic              is_last;
    logic [BYTE_W-1:0] cur_byte;
    logic              beat_full;
    logic              out_free;
    logic              advance;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  stk_diff;
    logic              push;
    logic [BEAT_BYTES-1:0][BYTE_W-1:0] pk;

    always_comb begin
        last_pos  = r_sp + {{(POS_W-1){1'b0}}, r_extra};
        is_last   = (r_pos == last_pos);
        cur_byte  = (r_pos == '0 || r_pos > r_sp) ? r_head : r_stk_q;
        beat_full = is_last || (r_pcnt == PCNT_W'(BEAT_BYTES - 1));
        out_free  = !r_ov || !i_stall;
        advance   = i_cmd.emit && (!beat_full || out_free);
        n_pos     = advance ? r_pos + 1'b1 : r_pos;
        stk_diff  = r_sp - n_pos;
        push      = i_cmd.walk && r_use_mem;
        pk        = r_pack;
        pk[r_pcnt] = cur_byte;
    end

    // The read address follows the next position, so the data matches r_pos.
    always_ff @(posedge i_clk) begin
        if (push) begin
            stack_mem[r_sp[IDX_W-1:0]] <= r_dict_q[BYTE_W-1:0];
        end
        r_stk_q <= stack_mem[stk_diff[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= NF_W'(ROOTS);
            r_prev_code <= '0;
            r_seen      <= 1'b0;
            r_halted    <= 1'b0;
            r_use_mem   <= 1'b0;
            r_sp        <= '0;
            r_pos       <= '0;
            r_pack      <= '0;
            r_pcnt      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_new_stream) begin
                    r_next_free <= NF_W'(ROOTS);
                end
                // A restart clears both flags before the code is judged.
                r_seen    <= eff_seen | (dec == DEC_FIRST);
                r_halted  <= (dec == DEC_ERR);
                r_sp      <= '0;
                r_pos     <= '0;
                r_use_mem <= 1'b0;
                r_code    <= i_code;
                r_extra   <= (dec == DEC_KWK);
                r_walk    <= (dec == DEC_KWK) ? r_prev_code : i_code;
                case (dec)
                    DEC_FIRST: begin
                        r_prev_code <= i_code;
                        r_head      <= i_code[BYTE_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (i_cmd.walk) begin
                if (push) r_sp <= r_sp + 1'b1;
                if (walk_done) begin
                    r_head <= cur[BYTE_W-1:0];
                end else begin
                    r_use_mem <= 1'b1;
                end
            end

            if (i_cmd.add) begin
                if (dict_we) r_next_free <= r_next_free + 1'b1;
                r_prev_code <= r_code;
            end

            if (advance) begin
                r_pos <= n_pos;
                if (beat_full) begin
                    r_pack <= '0;
                    r_pcnt <= '0;
                end else begin
                    r_pack <= pk;
                    r_pcnt <= r_pcnt + 1'b1;
                end
            end

            if ((advance && beat_full) || (i_cmd.err && out_free)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output beat payload.
    always_ff @(posedge i_clk) begin
        if (advance && beat_full) begin
            r_obytes <= pk;
            r_ocnt   <= BCNT_W'(r_pcnt) + 1'b1;
            r_olast  <= is_last;
            r_oerr   <= 1'b0;
        end else if (i_cmd.err && out_free) begin
            r_obytes <= '0;
            r_ocnt   <= '0;
            r_olast  <= 1'b1;
            r_oerr   <= 1'b1;
        end
    end

    assign o_status.dec       = dec;
    assign o_status.walk_done = walk_done;
    assign o_status.emit_done = advance && is_last;
    assign o_status.out_free  = out_free;

    assign o_valid      = r_ov;
    assign o_bytes      = r_obytes;
    assign o_byte_count = r_ocnt;
    assign o_last       = r_olast;
    assign o_error      = r_oerr;

endmodule

`default_nettype wire

### rtl/lzw_code_decoder.sv
// Top level of the LZW code decoder: sequencer plus datapath.
// Depends on lzwd_pkg, lzwd_ctrl and lzwd_dp.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------------
//  codes   | in        | i_valid / o_stall  | i_code, i_new_stream
//  bytes   | out       | o_valid / i_stall  | o_byte_0..7, o_byte_count, o_last, o_error
//
// One code passes through an accept step, a walk of its prefix chain, an add of
// the new dictionary entry and an emit of its output bytes. A first code skips
// the walk and the add; an error code goes straight from accept to its error beat.
// Reset is synchronous and active low; a stalled output holds its beat, and the
// packer waits only when a full beat has nowhere to go.
`timescale 1ns / 1ps
`default_nettype none

module lzw_code_decoder import lzwd_pkg::*; #(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [CODE_W-1:0]   i_code,
    input  wire                 i_new_stream,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [BYTE_W-1:0]   o_byte_0,
    output logic [BYTE_W-1:0]   o_byte_1,
    output logic [BYTE_W-1:0]   o_byte_2,
    output logic [BYTE_W-1:0]   o_byte_3,
    output logic [BYTE_W-1:0]   o_byte_4,
    output logic [BYTE_W-1:0]   o_byte_5,
    output logic [BYTE_W-1:0]   o_byte_6,
    output logic [BYTE_W-1:0]   o_byte_7,
    output logic [BCNT_W-1:0]   o_byte_count,
    output logic                o_last,
    output logic                o_error
);

    t_cmd    cmd;
    t_status status;
    logic [BEAT_BYTES-1:0][BYTE_W-1:0] bytes;

    lzwd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lzwd_dp #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code       (i_code),
        .i_new_stream (i_new_stream),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_bytes      (bytes),
        .o_byte_count (o_byte_count),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    assign o_byte_0 = bytes[0];
    assign o_byte_1 = bytes[1];
    assign o_byte_2 = bytes[2];
    assign o_byte_3 = bytes[3];
    assign o_byte_4 = bytes[4];
    assign o_byte_5 = bytes[5];
    assign o_byte_6 = bytes[6];
    assign o_byte_7 = bytes[7];

    // An error beat carries no bytes and closes its code.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> (o_byte_count == '0) && o_last)
        else $error("error beat with bytes or without last");

    // A data beat holds one to eight bytes.
    a_data_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> (o_byte_count != '0) && (o_byte_count <= BCNT_W'(BEAT_BYTES)))
        else $error("data beat byte count out of range");

    // Only the final beat of a code may be partly filled.
    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error && !o_last |-> (o_byte_count == BCNT_W'(BEAT_BYTES)))
        else $error("non-final beat not full");

    // The sequencer issues at most one command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.walk, cmd.add, cmd.emit, cmd.err}))
        else $error("more than one datapath command");

endmodule

`default_nettype wire
